// ===== hdl/tsb_pkg.sv =====
`default_nettype none
package tsb_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned CoordBits = 8;
  localparam int unsigned AddrBits  = 2 * CoordBits;
  localparam int unsigned TexBits   = 32;
  localparam int unsigned WidthBits = CoordBits + 1;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_WRAP   = 2'd0,
    CFG_FILTER = 2'd1,
    CFG_WIDTH  = 2'd2
  } cfg_idx_e;

  // Request handed from front to back: a texel write or four fetch addresses with weights.
  typedef struct packed {
    op_e                              op;
    logic                             bilinear;
    logic [3:0][AddrBits-1:0]         addr;
    logic [FracBits-1:0]              fx;
    logic [FracBits-1:0]              fy;
    logic [TexBits-1:0]               wdata;
  } req_t;

  typedef struct packed {
    logic push;
    logic full;
  } fifo_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } fifo_rd_t;

endpackage
`default_nettype wire

// ===== hdl/texture_sampler_bilinear_top.sv =====
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid/s_axis_tready    tuser opcode, tdata index/value/u/v
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata color
// cfg      in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// One item per cycle sustained barring stalls; a sample passes the front stages,
// the queue, then the registered texture read and two blend multiply stages.
// Two texture copies, two read ports each, give four texels per cycle unless stalled.
// Reset clears control state only; texture contents are undefined until written.
// Front and back stall independently through a 4-entry queue.
`default_nettype none
module texture_sampler_bilinear_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // texel_index, texel_value, coord_u, coord_v
  input  wire logic        s_axis_tuser,  // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // color
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [8:0]  cfg_data_i
);
  import tsb_pkg::*;

  req_t     wreq, rreq;
  fifo_wr_t fwr;
  fifo_rd_t frd;
  logic     full, pop;

  tsb_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_op_i(s_axis_tuser),
    .in_index_i(s_axis_tdata[15:0]), .in_value_i(s_axis_tdata[47:16]),
    .in_u_i(s_axis_tdata[71:48]), .in_v_i(s_axis_tdata[95:72]),
    .req_o(wreq), .fifo_wr_o(fwr), .fifo_full_i(full)
  );

  tsb_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(fwr), .wdata_i(wreq), .full_o(full),
    .pop_i(pop), .rd_o(frd), .rdata_o(rreq)
  );

  tsb_back u_back (
    .clk_i, .rst_ni, .rd_i(frd), .req_i(rreq), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_color_o(m_axis_tdata)
  );

endmodule
`default_nettype wire

// ===== hdl/tsb_ram.sv =====
`default_nettype none
module tsb_ram #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr0_i,
  input  wire logic [AW-1:0] raddr1_i,
  output logic      [DW-1:0] rdata0_o,
  output logic      [DW-1:0] rdata1_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tsb_front.sv =====
`default_nettype none
module tsb_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [8:0]            cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  in_op_i,
  input  wire logic [15:0]           in_index_i,
  input  wire logic [31:0]           in_value_i,
  input  wire logic [23:0]           in_u_i,
  input  wire logic [23:0]           in_v_i,
  output tsb_pkg::req_t              req_o,
  output tsb_pkg::fifo_wr_t          fifo_wr_o,
  input  wire logic                  fifo_full_i
);
  import tsb_pkg::*;

  localparam logic signed [25:0] CoordOne = 26'sd1 <<< FracBits;

  logic                    wrap_q, filt_q;
  logic [WidthBits-1:0]    width_q;
  logic [WidthBits-1:0]    w_eff;
  logic [CoordBits-1:0]    wm1;

  logic                    en;
  logic                    f1_vld_q, f2_vld_q, f3_vld_q;
  op_e                     f1_op_q, f2_op_q;
  logic [AddrBits-1:0]     f1_idx_q, f2_idx_q;
  logic [TexBits-1:0]      f1_val_q, f2_val_q;
  logic [FracBits:0]       cu_d, cv_d, cu_q, cv_q;
  logic [FracBits+CoordBits-1:0] su_q, sv_q;
  logic [FracBits+CoordBits:0]   pu, pv;
  req_t                    req_d, req_q;

  logic signed [25:0]      u_s, v_s;
  logic [CoordBits-1:0]    x0, y0, x1, y1;

  function automatic logic [FracBits:0] fix_coord(input logic signed [25:0] c,
                                                  input logic wrap);
    logic [FracBits:0] r;
    if (wrap) begin
      r = {1'b0, c[FracBits-1:0]};
    end else if (c < 26'sd0) begin
      r = '0;
    end else if (c > CoordOne) begin
      r = {1'b1, {FracBits{1'b0}}};
    end else begin
      r = c[FracBits:0];
    end
    return r;
  endfunction

  function automatic logic [CoordBits-1:0] pick(input logic [FracBits+CoordBits-1:0] s,
                                                input logic bilin,
                                                input logic [CoordBits-1:0] lim);
    logic [FracBits+CoordBits:0] r;
    logic [CoordBits:0]          c;
    if (bilin) begin
      r = {1'b0, s};
    end else begin
      r = {1'b0, s} + (FracBits+CoordBits+1)'(1 << (FracBits - 1));
    end
    c = r[FracBits+CoordBits:FracBits];
    return (c > {1'b0, lim}) ? lim : c[CoordBits-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q  <= 1'b0;
      filt_q  <= 1'b0;
      width_q <= WidthBits'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WRAP:   wrap_q  <= cfg_data_i[0];
        CFG_FILTER: filt_q  <= cfg_data_i[0];
        CFG_WIDTH:  width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = WidthBits'(1);
    end else if (width_q > WidthBits'(1 << CoordBits)) begin
      w_eff = WidthBits'(1 << CoordBits);
    end else begin
      w_eff = width_q;
    end
  end
  assign wm1 = CoordBits'(w_eff - WidthBits'(1));

  assign en          = !f3_vld_q || !fifo_full_i;
  assign in_ready_o  = en;
  assign fifo_wr_o.push = f3_vld_q && !fifo_full_i;
  assign fifo_wr_o.full = fifo_full_i;
  assign req_o       = req_q;

  // stage 1: flip v, clamp or wrap
  assign u_s  = 26'(signed'(in_u_i));
  assign v_s  = CoordOne - 26'(signed'(in_v_i));
  assign cu_d = fix_coord(u_s, wrap_q);
  assign cv_d = fix_coord(v_s, wrap_q);

  // stage 2: scale by width-1
  assign pu = (FracBits+CoordBits+1)'(cu_q) * (FracBits+CoordBits+1)'(wm1);
  assign pv = (FracBits+CoordBits+1)'(cv_q) * (FracBits+CoordBits+1)'(wm1);

  // stage 3: texel positions, neighbours clamped to last column/row, addresses
  always_comb begin
    x0 = pick(su_q, filt_q, wm1);
    y0 = pick(sv_q, filt_q, wm1);
    x1 = (x0 < wm1) ? x0 + CoordBits'(1) : wm1;
    y1 = (y0 < wm1) ? y0 + CoordBits'(1) : wm1;
    req_d.op       = f2_op_q;
    req_d.bilinear = filt_q;
    req_d.fx       = su_q[FracBits-1:0];
    req_d.fy       = sv_q[FracBits-1:0];
    req_d.wdata    = f2_val_q;
    if (f2_op_q == OP_WRITE) begin
      req_d.addr = {4{f2_idx_q}};
    end else begin
      req_d.addr[0] = AddrBits'(AddrBits'(y0) * AddrBits'(w_eff) + AddrBits'(x0));
      req_d.addr[1] = AddrBits'(AddrBits'(y0) * AddrBits'(w_eff) + AddrBits'(x1));
      req_d.addr[2] = AddrBits'(AddrBits'(y1) * AddrBits'(w_eff) + AddrBits'(x0));
      req_d.addr[3] = AddrBits'(AddrBits'(y1) * AddrBits'(w_eff) + AddrBits'(x1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= in_valid_i;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_op_q  <= op_e'(in_op_i);
      f1_idx_q <= in_index_i;
      f1_val_q <= in_value_i;
      cu_q     <= cu_d;
      cv_q     <= cv_d;
      f2_op_q  <= f1_op_q;
      f2_idx_q <= f1_idx_q;
      f2_val_q <= f1_val_q;
      su_q     <= pu[FracBits+CoordBits-1:0];
      sv_q     <= pv[FracBits+CoordBits-1:0];
      req_q    <= req_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tsb_fifo.sv =====
`default_nettype none
module tsb_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  tsb_pkg::fifo_wr_t      wr_i,
  input  tsb_pkg::req_t          wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output tsb_pkg::fifo_rd_t      rd_o,
  output tsb_pkg::req_t          rdata_o
);
  import tsb_pkg::*;

  req_t                 mem_q [FifoDepth];
  logic [FifoPtrW-1:0]  wp_q, rp_q;
  logic [FifoPtrW:0]    cnt_q;
  logic                 push, empty;

  assign full_o   = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign empty    = (cnt_q == '0);
  assign push     = wr_i.push;
  assign rd_o.pop   = pop_i;
  assign rd_o.empty = empty;
  assign rdata_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + FifoPtrW'(1);
      if (pop_i) rp_q <= rp_q + FifoPtrW'(1);
      if (push && !pop_i) begin
        cnt_q <= cnt_q + (FifoPtrW+1)'(1);
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - (FifoPtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wdata_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full_o)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty)) else $error("queue pop while empty");
  a_cnt_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[FifoPtrW-1:0] == FifoPtrW'(wp_q - rp_q))) else $error("queue count mismatch");

endmodule
`default_nettype wire

// ===== hdl/tsb_back.sv =====
`default_nettype none
module tsb_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  tsb_pkg::fifo_rd_t    rd_i,
  input  tsb_pkg::req_t        req_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [31:0]          out_color_o
);
  import tsb_pkg::*;

  logic                  en, we;
  logic [TexBits-1:0]    c00, c01, c10, c11;
  logic                  b1_vld_q, b1_bil_q;
  logic [FracBits-1:0]   b1_fx_q, b1_fy_q;
  logic                  b2_vld_q, b2_bil_q;
  logic [FracBits:0]     b2_gy_q;
  logic [FracBits-1:0]   b2_fy_q;
  logic [TexBits-1:0]    b2_c00_q;
  logic [3:0][23:0]      top_q, bot_q, top_d, bot_d;
  logic [FracBits:0]     gx;
  logic [3:0][7:0]       blend;
  logic                  b3_vld_q;
  logic [TexBits-1:0]    b3_color_q;

  assign en    = !b3_vld_q || out_ready_i;
  assign pop_o = en && !rd_i.empty;
  assign we    = pop_o && (req_i.op == OP_WRITE);

  tsb_ram #(.AW(AddrBits), .DW(TexBits)) u_ram_top (
    .clk_i, .we_i(we), .waddr_i(req_i.addr[0]), .wdata_i(req_i.wdata), .re_i(en),
    .raddr0_i(req_i.addr[0]), .raddr1_i(req_i.addr[1]), .rdata0_o(c00), .rdata1_o(c01)
  );
  tsb_ram #(.AW(AddrBits), .DW(TexBits)) u_ram_bot (
    .clk_i, .we_i(we), .waddr_i(req_i.addr[0]), .wdata_i(req_i.wdata), .re_i(en),
    .raddr0_i(req_i.addr[2]), .raddr1_i(req_i.addr[3]), .rdata0_o(c10), .rdata1_o(c11)
  );

  assign gx = (FracBits+1)'(1 << FracBits) - (FracBits+1)'(b1_fx_q);

  // horizontal blend per channel
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      top_d[ch] = 24'(25'(c00[ch*8 +: 8]) * 25'(gx) + 25'(c01[ch*8 +: 8]) * 25'(b1_fx_q));
      bot_d[ch] = 24'(25'(c10[ch*8 +: 8]) * 25'(gx) + 25'(c11[ch*8 +: 8]) * 25'(b1_fx_q));
    end
  end

  // vertical blend, truncated
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      blend[ch] = 8'((41'(top_q[ch]) * 41'(b2_gy_q) + 41'(bot_q[ch]) * 41'(b2_fy_q))
                     >> (2 * FracBits));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
      b3_vld_q <= 1'b0;
    end else if (en) begin
      b1_vld_q <= pop_o && (req_i.op == OP_SAMPLE);
      b2_vld_q <= b1_vld_q;
      b3_vld_q <= b2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_bil_q   <= req_i.bilinear;
      b1_fx_q    <= req_i.fx;
      b1_fy_q    <= req_i.fy;
      b2_bil_q   <= b1_bil_q;
      b2_fy_q    <= b1_fy_q;
      b2_gy_q    <= (FracBits+1)'(1 << FracBits) - (FracBits+1)'(b1_fy_q);
      b2_c00_q   <= c00;
      top_q      <= top_d;
      bot_q      <= bot_d;
      b3_color_q <= b2_bil_q ? blend : b2_c00_q;
    end
  end

  assign out_valid_o = b3_vld_q;
  assign out_color_o = b3_color_q;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !rd_i.empty) else $error("pop from empty queue");
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && pop_o && req_i.op == OP_WRITE) |=> !b1_vld_q) else $error("write made a result");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b3_vld_q && !out_ready_i) |=> (b3_vld_q && $stable(b3_color_q)))
    else $error("result lost on stall");

endmodule
`default_nettype wire

// ===== test/texture_sampler_bilinear_top_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module texture_sampler_bilinear_top_test;
  import tsb_pkg::*;

  localparam int unsigned FxOne = 1 << FracBits;
  localparam int unsigned MemDepth = 65536;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // texel_index, texel_value, coord_u, coord_v
  logic        s_axis_tuser = 1'b0; // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // color
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [8:0]  cfg_data_i = '0;

  texture_sampler_bilinear_top u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct {
    op_e         op;
    logic [15:0] index;
    logic [31:0] value;
    logic [23:0] u;
    logic [23:0] v;
    logic        known;   // expected color typed in
    logic [31:0] color;
  } row_t;

  // shadow of the block
  logic [31:0] texels [MemDepth];
  bit          written [MemDepth];
  logic        wrap_q, filt_q;
  logic [8:0]  width_q;

  logic [31:0] colors_due [$];
  int unsigned errors, samples_seen, writes_sent, bilinear_cnt, nearest_cnt;
  int unsigned idle_cycles;
  bit          rx_hold;   // long receiver stall requested
  bit          stim_done;

  function automatic longint unsigned fold_coord(longint signed c);
    if (wrap_q) return longint'(c) & (FxOne - 1);
    if (c < 0) return 0;
    if (c > FxOne) return FxOne;
    return c;
  endfunction

  function automatic int unsigned eff_width();
    if (width_q == 0) return 1;
    if (width_q > 256) return 256;
    return width_q;
  endfunction

  function automatic logic [31:0] texel_at(int unsigned idx);
    if (idx >= MemDepth) return '0;
    return texels[idx];
  endfunction

  function automatic logic [31:0] predict_color(logic [23:0] u, logic [23:0] v);
    int unsigned w, x0, y0, x1, y1;
    longint unsigned su, sv, fx, fy, gx, gy, top, bot, ch;
    logic [31:0] c00, c01, c10, c11, res;
    w = eff_width();
    su = fold_coord(longint'(signed'(u))) * (w - 1);
    sv = fold_coord(longint'(FxOne) - longint'(signed'(v))) * (w - 1);
    if (!filt_q) begin
      x0 = (su + FxOne / 2) >> FracBits;
      y0 = (sv + FxOne / 2) >> FracBits;
      if (x0 > w - 1) x0 = w - 1;
      if (y0 > w - 1) y0 = w - 1;
      return texel_at(y0 * w + x0);
    end
    x0 = su >> FracBits;
    y0 = sv >> FracBits;
    fx = su & (FxOne - 1);
    fy = sv & (FxOne - 1);
    gx = FxOne - fx;
    gy = FxOne - fy;
    if (x0 > w - 1) x0 = w - 1;
    if (y0 > w - 1) y0 = w - 1;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < w) ? y0 + 1 : w - 1;
    c00 = texel_at(y0 * w + x0);
    c01 = texel_at(y0 * w + x1);
    c10 = texel_at(y1 * w + x0);
    c11 = texel_at(y1 * w + x1);
    res = '0;
    for (int sh = 0; sh < 32; sh += 8) begin
      top = c00[sh +: 8] * gx + c01[sh +: 8] * fx;
      bot = c10[sh +: 8] * gx + c11[sh +: 8] * fx;
      ch = (top * gy + bot * fy) >> (2 * FracBits);
      if (ch > 255) ch = 255;
      res[sh +: 8] = ch[7:0];
    end
    return res;
  endfunction

  function automatic bit footprint_written(logic [23:0] u, logic [23:0] v);
    int unsigned w, x0, y0;
    longint unsigned su, sv;
    w = eff_width();
    su = fold_coord(longint'(signed'(u))) * (w - 1);
    sv = fold_coord(longint'(FxOne) - longint'(signed'(v))) * (w - 1);
    x0 = su >> FracBits;
    y0 = sv >> FracBits;
    // conservative: both candidate columns and rows
    for (int dy = 0; dy < 2; dy++)
      for (int dx = 0; dx < 2; dx++)
        if (!written[((y0 + dy < w) ? y0 + dy : w - 1) * w
                     + ((x0 + dx < w) ? x0 + dx : w - 1)]) return 0;
    return 1;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [8:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WRAP:   wrap_q  = data[0];
      CFG_FILTER: filt_q  = data[0];
      CFG_WIDTH:  width_q = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (colors_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    s_axis_tvalid <= 1'b0;
    if (r < 95) repeat ($urandom_range(1, 3)) @(posedge clk_i);
    else repeat ($urandom_range(10, 40)) @(posedge clk_i);
  endtask

  // one request; expected color queued at acceptance
  task automatic send_req(row_t r, bit gaps);
    if (gaps) sender_gap();
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {r.v, r.u, r.value, r.index};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (r.op == OP_WRITE) begin
      texels[r.index] = r.value;
      written[r.index] = 1'b1;
      writes_sent++;
    end else begin
      if (r.known && r.color != predict_color(r.u, r.v))
        $display("%0t: note: table color %h differs from prediction", $time, r.color);
      colors_due.push_back(r.known ? r.color : predict_color(r.u, r.v));
      if (filt_q) bilinear_cnt++; else nearest_cnt++;
    end
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic row_t wr_row(logic [15:0] idx, logic [31:0] val);
    row_t r;
    r = '{OP_WRITE, idx, val, '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t smp_row(logic [23:0] u, logic [23:0] v, logic known,
                                   logic [31:0] col);
    row_t r;
    r = '{OP_SAMPLE, 16'($urandom), 32'($urandom), u, v, known, col};
    return r;
  endfunction

  // fill a w x w texture, random texels with a few extremes
  task automatic fill_texture(int unsigned w, bit gaps);
    logic [31:0] val;
    for (int unsigned i = 0; i < w * w; i++) begin
      case ($urandom_range(0, 9))
        0: val = '0;
        1: val = '1;
        default: val = $urandom;
      endcase
      send_req(wr_row(i[15:0], val), gaps);
    end
  endtask

  // large texture: only the 2x2 texels at each corner, where extreme coordinates land
  task automatic fill_corners(int unsigned w, bit gaps);
    int unsigned pos [4];
    pos = '{0, 1, w - 2, w - 1};
    for (int j = 0; j < 4; j++)
      for (int k = 0; k < 4; k++)
        send_req(wr_row(16'(pos[j] * w + pos[k]), $urandom), gaps);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h010000;
      3: return 24'h000000;
      4: return 24'($urandom);
      5: return 24'(FxOne + $urandom_range(0, 3) - 1);
      default: return 24'($urandom_range(0, FxOne + 8)) - 24'd4;
    endcase
  endfunction

  // receiver: random stalls, plus a long hold when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk_i);
        rx_hold = 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 99) < 90 ? $urandom_range(1, 3)
                                           : $urandom_range(10, 40)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (colors_due.size() == 0) begin
        $display("%0t: unexpected color %h", $time, m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata !== colors_due[0]) begin
          $display("%0t: color expected %h actual %h", $time, colors_due[0], m_axis_tdata);
          errors++;
        end
        void'(colors_due.pop_front());
      end
      samples_seen++;
    end
  end

  // watchdog on accepted requests of any kind
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("%0t: timeout, %0d colors pending", $time, colors_due.size());
      $display("texture_sampler_bilinear_top_test: errors");
      $finish;
    end
  end

  initial begin
    row_t        dir [$];
    int unsigned sizes [6] = '{1, 2, 3, 5, 16, 256};
    int unsigned w, sent, nsamp;
    errors = 0;
    wrap_q = 1'b0;
    filt_q = 1'b0;
    width_q = 9'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: width 1 after reset, every sample hits texel 0
    dir.push_back(wr_row(16'd0, 32'hFFFF_FFFF));
    dir.push_back(smp_row(24'h000000, 24'h000000, 1'b1, 32'hFFFF_FFFF));
    dir.push_back(smp_row(24'h7FFFFF, 24'h800000, 1'b1, 32'hFFFF_FFFF));
    dir.push_back(smp_row(24'h800000, 24'h7FFFFF, 1'b1, 32'hFFFF_FFFF));
    dir.push_back(wr_row(16'd0, 32'h0000_0000));
    dir.push_back(smp_row(24'h008000, 24'h008000, 1'b1, 32'h0000_0000));
    dir.push_back(wr_row(16'hFFFF, 32'hA5A5_5A5A));
    dir.push_back(wr_row(16'd0, 32'h1234_5678));
    dir.push_back(smp_row(24'h010000, 24'h010000, 1'b1, 32'h1234_5678));
    foreach (dir[i]) send_req(dir[i], 1'b0);
    idle_input();
    drain();

    // width 2, clamp, nearest then bilinear; corners and midpoints
    write_reg(CFG_WIDTH, 9'd2);
    fill_texture(2, 1'b0);
    idle_input();
    for (int f = 0; f < 2; f++) begin
      drain();
      write_reg(CFG_FILTER, 9'(f));
      dir.delete();
      dir.push_back(smp_row(24'h000000, 24'h010000, 1'b0, '0)); // top-left
      dir.push_back(smp_row(24'h010000, 24'h000000, 1'b0, '0)); // bottom-right
      dir.push_back(smp_row(24'h008000, 24'h008000, 1'b0, '0)); // rounding half up
      dir.push_back(smp_row(24'h007FFF, 24'h00FFFF, 1'b0, '0));
      dir.push_back(smp_row(24'hFF0000, 24'h020000, 1'b0, '0)); // clamp both ends
      foreach (dir[i]) send_req(dir[i], 1'b0);
      idle_input();
    end
    // wrap: coordinate exactly one wraps to zero
    drain();
    write_reg(CFG_WRAP, 9'd1);
    send_req(smp_row(24'h010000, 24'h010000, 1'b0, '0), 1'b0);
    send_req(smp_row(24'h018000, 24'hFE4000, 1'b0, '0), 1'b0);
    idle_input();

    // random phases over sizes and modes
    sent = 0;
    for (int ph = 0; sent < 1500; ph++) begin
      drain();
      w = sizes[ph % 6];
      if (ph == 7) w = 0;   // width zero acts as one
      write_reg(CFG_WIDTH, (ph == 9) ? 9'd300 : 9'(w));
      write_reg(CFG_WRAP, 9'($urandom_range(0, 1)));
      write_reg(CFG_FILTER, 9'($urandom_range(0, 1)));
      w = eff_width();
      if (w <= 16) fill_texture(w, 1'b1);
      else fill_corners(w, 1'b1);
      sent += (w <= 16) ? w * w : 16;
      nsamp = 120;
      for (int i = 0; i < nsamp; i++) begin
        row_t r;
        if ($urandom_range(0, 9) == 0) begin
          logic [15:0] idx;
          idx = 16'($urandom_range(0, w * w - 1));
          if ($urandom_range(0, 3) == 0) idx = 16'($urandom);   // stray writes anywhere
          r = wr_row(idx, $urandom);
        end else begin
          r = smp_row(rand_coord(), rand_coord(), 1'b0, '0);
          while (!footprint_written(r.u, r.v)) r = smp_row(rand_coord(), rand_coord(), 1'b0, '0);
        end
        if (ph == 2 && i == 10) rx_hold = 1'b1;   // long back-pressure
        send_req(r, !(ph == 2 && i < 60));
        sent++;
      end
      idle_input();
      if (ph == 4) drain();   // sender waits for every color
    end

    idle_input();
    drain();
    $display("covered %0d texel writes, %0d nearest and %0d bilinear samples, %0d colors",
             writes_sent, nearest_cnt, bilinear_cnt, samples_seen);
    if (errors == 0) begin
      $display("texture_sampler_bilinear_top_test: clean");
    end else begin
      $display("texture_sampler_bilinear_top_test: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/tsb_pkg.sv
hdl/tsb_ram.sv
hdl/tsb_front.sv
hdl/tsb_fifo.sv
hdl/tsb_back.sv
hdl/texture_sampler_bilinear_top.sv
test/texture_sampler_bilinear_top_test.sv
